@@ src/srs_pkg.sv @@
package srs_pkg;

    // Configuration port geometry
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Field widths
    localparam int COUNT_W   = 16;
    localparam int QUALITY_W = 3;
    localparam int DAY_W     = 22;
    localparam int DUE_W     = 23;
    localparam int PROD_W    = 2 * COUNT_W;

    localparam logic [COUNT_W-1:0] MAX16 = '1;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PASS_GRADE   = 3'd0,
        CFG_STEP1_DAYS   = 3'd1,
        CFG_STEP2_DAYS   = 3'd2,
        CFG_STEP3_DAYS   = 3'd3,
        CFG_EASE_FLOOR   = 3'd4,
        CFG_MASTERY_DAYS = 3'd5,
        CFG_INITIAL_EASE = 3'd6
    } cfg_reg_t;

    // Configuration reset values
    localparam logic [QUALITY_W-1:0] RST_PASS_GRADE   = 3'd3;
    localparam logic [COUNT_W-1:0]   RST_STEP1_DAYS   = 16'd1;
    localparam logic [COUNT_W-1:0]   RST_STEP2_DAYS   = 16'd6;
    localparam logic [COUNT_W-1:0]   RST_STEP3_DAYS   = 16'd15;
    localparam logic [COUNT_W-1:0]   RST_EASE_FLOOR   = 16'd130;
    localparam logic [COUNT_W-1:0]   RST_MASTERY_DAYS = 16'd21;
    localparam logic [COUNT_W-1:0]   RST_INITIAL_EASE = 16'd250;

    // Rounded divide by 100: (p + 50) / 100, exact for x < 2^23 with shift 30
    localparam logic [PROD_W:0]   ROUND_BIAS     = 33'd50;
    localparam logic [PROD_W-1:0] PROD_SAT_LIMIT = 32'd6553550;
    localparam int                DIV_IN_W       = 23;
    localparam int                DIV_MULT_W     = 24;
    localparam int                DIV_PROD_W     = DIV_IN_W + DIV_MULT_W;
    localparam logic [DIV_MULT_W-1:0] DIV100_MULT = 24'd10737419;
    localparam int                DIV100_SHIFT   = 30;

    typedef struct packed {
        logic [QUALITY_W-1:0] pass_grade;
        logic [COUNT_W-1:0]   step1_days;
        logic [COUNT_W-1:0]   step2_days;
        logic [COUNT_W-1:0]   step3_days;
        logic [COUNT_W-1:0]   ease_floor;
        logic [COUNT_W-1:0]   mastery_days;
        logic [COUNT_W-1:0]   initial_ease;
    } cfg_t;

    // One review as taken from the input channel
    typedef struct packed {
        logic                 has_history;
        logic [COUNT_W-1:0]   prior_reps;
        logic [COUNT_W-1:0]   prior_lapses;
        logic [COUNT_W-1:0]   prior_interval;
        logic [COUNT_W-1:0]   prior_ease;
        logic [QUALITY_W-1:0] answer_quality;
        logic [DAY_W-1:0]     today_day;
    } item_t;

    // After the grade evaluation and the interval product
    typedef struct packed {
        logic [COUNT_W-1:0] reps;
        logic [COUNT_W-1:0] lapses;
        logic [COUNT_W-1:0] ease;
        logic [COUNT_W-1:0] fixed_interval;
        logic               use_product;
        logic [PROD_W-1:0]  product;
        logic [DAY_W-1:0]   today;
    } eval_t;

    // After the interval is settled
    typedef struct packed {
        logic [COUNT_W-1:0] reps;
        logic [COUNT_W-1:0] lapses;
        logic [COUNT_W-1:0] ease;
        logic [COUNT_W-1:0] interval;
        logic [DAY_W-1:0]   today;
    } sched_t;

    // Ease change in hundredths for a grade; grades above five act as five
    function automatic logic signed [7:0] ease_delta(input logic [QUALITY_W-1:0] quality);
        logic signed [7:0] delta;
        begin
            case (quality)
                3'd0:    delta = -8'sd80;
                3'd1:    delta = -8'sd54;
                3'd2:    delta = -8'sd32;
                3'd3:    delta = -8'sd14;
                3'd4:    delta = 8'sd0;
                default: delta = 8'sd10;
            endcase
            return delta;
        end
    endfunction

endpackage

@@ src/srs_cfg.sv @@
module srs_cfg
    import srs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write into the addressed register
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_PASS_GRADE:   cfg_next.pass_grade   = cfg_data[QUALITY_W-1:0];
                CFG_STEP1_DAYS:   cfg_next.step1_days   = cfg_data;
                CFG_STEP2_DAYS:   cfg_next.step2_days   = cfg_data;
                CFG_STEP3_DAYS:   cfg_next.step3_days   = cfg_data;
                CFG_EASE_FLOOR:   cfg_next.ease_floor   = cfg_data;
                CFG_MASTERY_DAYS: cfg_next.mastery_days = cfg_data;
                CFG_INITIAL_EASE: cfg_next.initial_ease = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pass_grade   <= RST_PASS_GRADE;
            cfg_reg.step1_days   <= RST_STEP1_DAYS;
            cfg_reg.step2_days   <= RST_STEP2_DAYS;
            cfg_reg.step3_days   <= RST_STEP3_DAYS;
            cfg_reg.ease_floor   <= RST_EASE_FLOOR;
            cfg_reg.mastery_days <= RST_MASTERY_DAYS;
            cfg_reg.initial_ease <= RST_INITIAL_EASE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/srs_eval.sv @@
module srs_eval
    import srs_pkg::*;
(
    input  item_t item,
    input  cfg_t  cfg,
    output eval_t res
);

    logic [COUNT_W-1:0]  reps;
    logic [COUNT_W-1:0]  lapses;
    logic [COUNT_W-1:0]  interval;
    logic [COUNT_W-1:0]  ease;
    logic [COUNT_W-1:0]  reps_inc;
    logic [COUNT_W-1:0]  lapses_inc;
    logic                passed;
    logic signed [17:0]  delta_ext;
    logic signed [17:0]  ease_sum;
    logic [COUNT_W-1:0]  ease_new;

    // Drop the prior fields of a new card
    assign reps     = item.has_history ? item.prior_reps     : '0;
    assign lapses   = item.has_history ? item.prior_lapses   : '0;
    assign interval = item.has_history ? item.prior_interval : '0;
    assign ease     = item.has_history ? item.prior_ease     : cfg.initial_ease;

    assign passed     = (item.answer_quality >= cfg.pass_grade);
    assign reps_inc   = (reps == MAX16) ? MAX16 : reps + 16'd1;
    assign lapses_inc = (lapses == MAX16) ? MAX16 : lapses + 16'd1;

    // Apply the grade delta, clip at the top, then hold at the floor
    assign delta_ext = 18'(ease_delta(item.answer_quality));
    assign ease_sum  = $signed({2'b00, ease}) + delta_ext;

    always_comb
    begin
        if (ease_sum > $signed({2'b00, MAX16}))
        begin
            ease_new = MAX16;
        end
        else if (ease_sum < $signed({2'b00, cfg.ease_floor}))
        begin
            ease_new = cfg.ease_floor;
        end
        else
        begin
            ease_new = ease_sum[COUNT_W-1:0];
        end
    end

    // Pick counts and the fixed interval step
    always_comb
    begin
        res.reps           = reps;
        res.lapses         = lapses;
        res.fixed_interval = cfg.step1_days;
        res.use_product    = 1'b0;
        res.ease           = ease_new;
        // Interval times old ease, divided by 100 later
        res.product        = PROD_W'(interval) * PROD_W'(ease);
        res.today          = item.today_day;
        if (!passed)
        begin
            res.lapses = lapses_inc;
            res.reps   = '0;
        end
        else
        begin
            res.reps = reps_inc;
            case (reps_inc)
                16'd1:   res.fixed_interval = cfg.step1_days;
                16'd2:   res.fixed_interval = cfg.step2_days;
                16'd3:   res.fixed_interval = cfg.step3_days;
                default: res.use_product    = 1'b1;
            endcase
        end
    end

endmodule

@@ src/srs_div100.sv @@
module srs_div100
    import srs_pkg::*;
(
    input  eval_t  ev,
    output sched_t res
);

    logic [PROD_W:0]       biased;
    logic                  saturate;
    logic [DIV_PROD_W-1:0] scaled;
    logic [COUNT_W-1:0]    quotient;

    // Round half up, then divide by 100 through the reciprocal
    assign biased   = {1'b0, ev.product} + ROUND_BIAS;
    assign saturate = (ev.product >= PROD_SAT_LIMIT);
    assign scaled   = DIV_PROD_W'(biased[DIV_IN_W-1:0]) * DIV_PROD_W'(DIV100_MULT);
    assign quotient = COUNT_W'(scaled >> DIV100_SHIFT);

    // Select the scaled or the fixed interval
    always_comb
    begin
        res.reps   = ev.reps;
        res.lapses = ev.lapses;
        res.ease   = ev.ease;
        res.today  = ev.today;
        if (!ev.use_product)
        begin
            res.interval = ev.fixed_interval;
        end
        else if (saturate)
        begin
            res.interval = MAX16;
        end
        else
        begin
            res.interval = quotient;
        end
    end

endmodule

@@ src/spaced_repetition_scheduler_core.sv @@
// Channel  | Handshake                  | Payload
// ---------+----------------------------+-----------------------------------------------
// review   | item_valid / item_stall    | has_history, prior_*, answer_quality, today_day
// result   | result_valid / result_stall| new_*, mastered, due_day, last_review_day
// config   | cfg_we                     | cfg_index, cfg_data
//
// One transfer per cycle in steady state while result_stall is low; each review passes
// through the input, product, interval and result registers before its result is offered.
// The interval product and the divide-by-100 multiplier each sit in a stage of their own.
// Reset clears all stage valid bits and loads the default configuration.
// A stalled result holds its register; upstream stages keep filling empty slots and
// item_stall rises only when every stage ahead is occupied.
module spaced_repetition_scheduler_core
    import srs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  logic                   has_history,
    input  logic [COUNT_W-1:0]     prior_reps,
    input  logic [COUNT_W-1:0]     prior_lapses,
    input  logic [COUNT_W-1:0]     prior_interval,
    input  logic [COUNT_W-1:0]     prior_ease,
    input  logic [QUALITY_W-1:0]   answer_quality,
    input  logic [DAY_W-1:0]       today_day,
    output logic                   result_valid,
    input  logic                   result_stall,
    output logic [COUNT_W-1:0]     new_reps,
    output logic [COUNT_W-1:0]     new_lapses,
    output logic [COUNT_W-1:0]     new_interval,
    output logic [COUNT_W-1:0]     new_ease,
    output logic                   mastered,
    output logic [DUE_W-1:0]       due_day,
    output logic [DAY_W-1:0]       last_review_day
);

    cfg_t   cfg;
    item_t  item_reg;
    eval_t  eval_reg;
    eval_t  eval_next;
    sched_t sched_reg;
    sched_t sched_next;

    logic   item_vld_reg;
    logic   eval_vld_reg;
    logic   sched_vld_reg;
    logic   res_vld_reg;

    logic   res_ready;
    logic   sched_ready;
    logic   eval_ready;
    logic   item_ready;

    logic [COUNT_W-1:0] res_reps_reg;
    logic [COUNT_W-1:0] res_lapses_reg;
    logic [COUNT_W-1:0] res_interval_reg;
    logic [COUNT_W-1:0] res_ease_reg;
    logic               res_mastered_reg;
    logic [DUE_W-1:0]   res_due_reg;
    logic [DAY_W-1:0]   res_today_reg;
    logic               res_mastered_next;
    logic [DUE_W-1:0]   res_due_next;

    srs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    srs_eval u_eval (
        .item (item_reg),
        .cfg  (cfg),
        .res  (eval_next)
    );

    srs_div100 u_div100 (
        .ev  (eval_reg),
        .res (sched_next)
    );

    // Advance a stage when its slot is empty or its contents move on
    assign res_ready   = !res_vld_reg   || !result_stall;
    assign sched_ready = !sched_vld_reg || res_ready;
    assign eval_ready  = !eval_vld_reg  || sched_ready;
    assign item_ready  = !item_vld_reg  || eval_ready;
    assign item_stall  = !item_ready;

    // Mastery test and due day
    assign res_mastered_next = (sched_reg.interval >= cfg.mastery_days);
    assign res_due_next      = DUE_W'(sched_reg.today) + DUE_W'(sched_reg.interval);

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg  <= 1'b0;
            eval_vld_reg  <= 1'b0;
            sched_vld_reg <= 1'b0;
            res_vld_reg   <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                item_vld_reg <= item_valid;
            end
            if (eval_ready)
            begin
                eval_vld_reg <= item_vld_reg;
            end
            if (sched_ready)
            begin
                sched_vld_reg <= eval_vld_reg;
            end
            if (res_ready)
            begin
                res_vld_reg <= sched_vld_reg;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (item_ready)
        begin
            item_reg.has_history    <= has_history;
            item_reg.prior_reps     <= prior_reps;
            item_reg.prior_lapses   <= prior_lapses;
            item_reg.prior_interval <= prior_interval;
            item_reg.prior_ease     <= prior_ease;
            item_reg.answer_quality <= answer_quality;
            item_reg.today_day      <= today_day;
        end
        if (eval_ready)
        begin
            eval_reg <= eval_next;
        end
        if (sched_ready)
        begin
            sched_reg <= sched_next;
        end
        if (res_ready)
        begin
            res_reps_reg     <= sched_reg.reps;
            res_lapses_reg   <= sched_reg.lapses;
            res_interval_reg <= sched_reg.interval;
            res_ease_reg     <= sched_reg.ease;
            res_mastered_reg <= res_mastered_next;
            res_due_reg      <= res_due_next;
            res_today_reg    <= sched_reg.today;
        end
    end

    assign result_valid    = res_vld_reg;
    assign new_reps        = res_reps_reg;
    assign new_lapses      = res_lapses_reg;
    assign new_interval    = res_interval_reg;
    assign new_ease        = res_ease_reg;
    assign mastered        = res_mastered_reg;
    assign due_day         = res_due_reg;
    assign last_review_day = res_today_reg;

    // Input backs up only when the whole pipeline is full behind a stalled result
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (item_vld_reg && eval_vld_reg && sched_vld_reg
                        && res_vld_reg && result_stall))
        else $error("item_stall raised with an empty pipeline slot");

    // Due day is review day plus the delivered interval
    a_due_sum: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (due_day == (DUE_W'(last_review_day) + DUE_W'(new_interval))))
        else $error("due_day does not match review day plus interval");

    // Ease never delivered below its floor
    a_ease_floor: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (new_ease >= cfg.ease_floor))
        else $error("new_ease below ease_floor");

    // Mastery flag agrees with the delivered interval
    a_mastered: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (mastered == (new_interval >= cfg.mastery_days)))
        else $error("mastered flag inconsistent with new_interval");

endmodule
